[design/dbfp_pkg.sv]
//------------------------------------------------------------------------------
// dbfp_pkg
// Shared types, codes and constants of the document bundle frame parser.
//------------------------------------------------------------------------------
`default_nettype none

package dbfp_pkg;

    localparam int BYTE_W              = 8;
    localparam int IN_LEN_W            = 13;
    localparam int ACC_W               = 32;
    localparam int FEP_W               = ACC_W + 1;
    localparam int ROLE_W              = 2;
    localparam int FMT_W               = 2;
    localparam int CFG_IDX_W           = 2;
    localparam int MAX_FRAME_BYTES_DEF = 4096;
    localparam int WORD_BYTES          = 4;
    localparam int LEN_PAIR_BYTES      = 2 * WORD_BYTES;

    // byte roles
    localparam logic [ROLE_W-1:0] ROLE_NONE  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_INDEX = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_BODY  = 2'd2;

    // frame formats
    localparam logic [FMT_W-1:0] FMT_LEGACY  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_V1      = 2'd1;
    localparam logic [FMT_W-1:0] FMT_V2      = 2'd2;
    localparam logic [FMT_W-1:0] FMT_UNKNOWN = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_MAGIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V1_MAGIC     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V2_MAGIC     = 2'd2;

    localparam logic [BYTE_W-1:0] LEGACY_MAGIC_RST = 8'd0;
    localparam logic [BYTE_W-1:0] V1_MAGIC_RST     = 8'd1;
    localparam logic [BYTE_W-1:0] V2_MAGIC_RST     = 8'd2;

    typedef enum logic [3:0] {
        PH_MAGIC = 4'd0,
        PH_VER   = 4'd1,
        PH_ILEN  = 4'd2,
        PH_IDX   = 4'd3,
        PH_BLEN  = 4'd4,
        PH_BODY  = 4'd5,
        PH_PAD   = 4'd6,
        PH_FAIL  = 4'd7,
        PH_LIDX  = 4'd8,
        PH_LREST = 4'd9,
        PH_UNK   = 4'd10
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] legacy_magic;
        logic [BYTE_W-1:0] v1_magic;
        logic [BYTE_W-1:0] v2_magic;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [ROLE_W-1:0] byte_role;
        logic              frame_done;
        logic              frame_ok;
        logic [ACC_W-1:0]  frame_ver;
        logic [FMT_W-1:0]  frame_format;
    } t_result;

endpackage

`default_nettype wire

[design/doc_bundle_frame_parser.sv]
//------------------------------------------------------------------------------
// doc_bundle_frame_parser
// Classifies the bytes of a document bundle frame and reports the verdict.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_frame_byte, i_frame_length
//   out      output     o_out_valid / i_out_ready  o_out_byte, o_byte_role,
//                                                  o_frame_done, o_frame_ok,
//                                                  o_frame_ver, o_frame_format
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// one word per cycle sustained while the out side is ready; a word accepted into the
// input register moves through one parse step into the result register
// the parse step updates the frame state as a word moves into the result register
// reset is synchronous, active low: parse state and valids are cleared, magics
// return to their defaults
// a stalled out side holds its word; the input register keeps taking words until
// both registers are full
//------------------------------------------------------------------------------
`default_nettype none

module doc_bundle_frame_parser #(
    parameter int MAX_FRAME_BYTES = dbfp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output wire logic                           o_in_ready,
    input  wire logic [dbfp_pkg::BYTE_W-1:0]    i_frame_byte,
    input  wire logic [dbfp_pkg::IN_LEN_W-1:0]  i_frame_length,
    output wire logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output wire logic [dbfp_pkg::BYTE_W-1:0]    o_out_byte,
    output wire logic [dbfp_pkg::ROLE_W-1:0]    o_byte_role,
    output wire logic                           o_frame_done,
    output wire logic                           o_frame_ok,
    output wire logic [dbfp_pkg::ACC_W-1:0]     o_frame_ver,
    output wire logic [dbfp_pkg::FMT_W-1:0]     o_frame_format,
    input  wire logic                           i_cfg_we,
    input  wire logic [dbfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dbfp_pkg::BYTE_W-1:0]    i_cfg_data
);
    import dbfp_pkg::*;

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [IN_LEN_W-1:0] r_in_len;
    logic                r_out_valid;
    t_result             r_out;
    t_result             step_result;
    t_cfg                cfg;
    logic                advance;

    // word moves from the input register to the result register
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    dbfp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dbfp_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_len    (r_in_len),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_frame_byte;
            r_in_len  <= i_frame_length;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out.out_byte;
    assign o_byte_role    = r_out.byte_role;
    assign o_frame_done   = r_out.frame_done;
    assign o_frame_ok     = r_out.frame_ok;
    assign o_frame_ver    = r_out.frame_ver;
    assign o_frame_format = r_out.frame_format;

endmodule

`default_nettype wire

[design/dbfp_cfg_regs.sv]
//------------------------------------------------------------------------------
// dbfp_cfg_regs
// Magic byte registers, written through the plain write port.
//------------------------------------------------------------------------------
`default_nettype none

module dbfp_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [dbfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dbfp_pkg::BYTE_W-1:0]    i_cfg_data,
    output dbfp_pkg::t_cfg                      o_cfg
);
    import dbfp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.legacy_magic <= LEGACY_MAGIC_RST;
            r_cfg.v1_magic     <= V1_MAGIC_RST;
            r_cfg.v2_magic     <= V2_MAGIC_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEGACY_MAGIC: r_cfg.legacy_magic <= i_cfg_data;
                CFG_V1_MAGIC:     r_cfg.v1_magic     <= i_cfg_data;
                CFG_V2_MAGIC:     r_cfg.v2_magic     <= i_cfg_data;
                default: begin
                    // index past the list: ignored
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[design/dbfp_parser.sv]
//------------------------------------------------------------------------------
// dbfp_parser
// Parse state machine: classifies one byte per step and tracks field bounds.
//------------------------------------------------------------------------------
`default_nettype none

module dbfp_parser #(
    parameter int MAX_FRAME_BYTES = dbfp_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [dbfp_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [dbfp_pkg::IN_LEN_W-1:0] i_len,
    input  wire dbfp_pkg::t_cfg                i_cfg,
    output dbfp_pkg::t_result                  o_result
);
    import dbfp_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES);
    localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW = (LW > IN_LEN_W) ? LW : IN_LEN_W;

    t_phase            r_phase, n_phase;
    logic [PW-1:0]     r_pos, n_pos;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [FEP_W-1:0]  r_fep, n_fep;
    logic [ACC_W-1:0]  r_ver, n_ver;
    logic [FMT_W-1:0]  r_fmt, n_fmt;
    logic              r_ok, n_ok;

    logic [CW-1:0]     len_ext;
    logic [LW-1:0]     len_c;
    logic [LW-1:0]     next;
    logic [FEP_W-1:0]  len_w;
    logic [FEP_W-1:0]  next_w;
    logic [ACC_W-1:0]  acc_sh;
    logic [FEP_W-1:0]  sum_w;
    logic              at_end;
    logic              done;
    logic              is_legacy, is_v1, is_v2;

    // clamp length into 1..MAX_FRAME_BYTES
    always_comb begin
        len_ext = CW'(i_len);
        if (len_ext == '0) begin
            len_c = LW'(1);
        end else if (len_ext > CW'(MAX_FRAME_BYTES)) begin
            len_c = LW'(MAX_FRAME_BYTES);
        end else begin
            len_c = LW'(len_ext);
        end
    end

    assign next      = LW'(r_pos) + LW'(1);
    assign len_w     = FEP_W'(len_c);
    assign next_w    = FEP_W'(next);
    assign acc_sh    = {i_byte, r_acc[ACC_W-1:BYTE_W]};
    assign sum_w     = next_w + FEP_W'(acc_sh);
    assign at_end    = next_w >= r_fep;
    assign done      = next >= len_c;
    assign is_legacy = i_byte == i_cfg.legacy_magic;
    assign is_v2     = i_byte == i_cfg.v2_magic;
    assign is_v1     = i_byte == i_cfg.v1_magic;

    // next state and field tracking
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_fep   = r_fep;
        n_ver   = r_ver;
        n_fmt   = r_fmt;
        n_ok    = r_ok;
        case (r_phase)
            PH_MAGIC: begin
                n_ver = '0;
                n_acc = '0;
                n_ok  = 1'b0;
                if (is_legacy) begin
                    n_fmt   = FMT_LEGACY;
                    n_phase = PH_LIDX;
                    n_ok    = 1'b1;
                end else if (is_v2) begin
                    n_fmt = FMT_V2;
                    if (len_w < next_w + FEP_W'(WORD_BYTES + LEN_PAIR_BYTES)) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_phase = PH_VER;
                        n_fep   = next_w + FEP_W'(WORD_BYTES);
                    end
                end else if (is_v1) begin
                    n_fmt = FMT_V1;
                    if (len_w < next_w + FEP_W'(LEN_PAIR_BYTES)) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_phase = PH_ILEN;
                        n_fep   = next_w + FEP_W'(WORD_BYTES);
                    end
                end else begin
                    n_fmt   = FMT_UNKNOWN;
                    n_phase = PH_UNK;
                end
            end
            PH_VER: begin
                n_acc = acc_sh;
                if (at_end) begin
                    n_ver   = acc_sh;
                    n_phase = PH_ILEN;
                    n_fep   = next_w + FEP_W'(WORD_BYTES);
                end
            end
            PH_ILEN: begin
                n_acc = acc_sh;
                if (at_end) begin
                    n_fep = sum_w;
                    if (sum_w > len_w) begin
                        n_phase = PH_FAIL;
                        n_ok    = 1'b0;
                    end else if (acc_sh == '0) begin
                        // empty index: go straight to the body length
                        if (sum_w + FEP_W'(WORD_BYTES) > len_w) begin
                            n_phase = PH_FAIL;
                            n_ok    = 1'b0;
                        end else begin
                            n_phase = PH_BLEN;
                            n_fep   = sum_w + FEP_W'(WORD_BYTES);
                        end
                    end else begin
                        n_phase = PH_IDX;
                    end
                end
            end
            PH_IDX: begin
                if (at_end) begin
                    if (r_fep + FEP_W'(WORD_BYTES) > len_w) begin
                        n_phase = PH_FAIL;
                        n_ok    = 1'b0;
                    end else begin
                        n_phase = PH_BLEN;
                        n_fep   = r_fep + FEP_W'(WORD_BYTES);
                    end
                end
            end
            PH_BLEN: begin
                n_acc = acc_sh;
                if (at_end) begin
                    n_fep = sum_w;
                    if (sum_w > len_w) begin
                        n_phase = PH_FAIL;
                        n_ok    = 1'b0;
                    end else if (acc_sh == '0) begin
                        n_phase = PH_PAD;
                        n_ok    = 1'b1;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (at_end) begin
                    n_phase = PH_PAD;
                    n_ok    = 1'b1;
                end
            end
            PH_LIDX: begin
                if (i_byte == '0) begin
                    n_phase = PH_LREST;
                end
            end
            PH_FAIL: begin
                n_ok = 1'b0;
            end
            default: begin
            end
        endcase
        if (done) begin
            n_phase = PH_MAGIC;
            n_pos   = '0;
        end else begin
            n_pos = PW'(next);
        end
    end

    // result of this step
    always_comb begin
        o_result.out_byte = i_byte;
        case (r_phase)
            PH_MAGIC: o_result.byte_role = (is_legacy || is_v2 || is_v1) ? ROLE_NONE
                                                                         : ROLE_BODY;
            PH_IDX:   o_result.byte_role = ROLE_INDEX;
            PH_BODY:  o_result.byte_role = ROLE_BODY;
            PH_LIDX:  o_result.byte_role = (i_byte != '0) ? ROLE_INDEX : ROLE_NONE;
            PH_UNK:   o_result.byte_role = ROLE_BODY;
            default:  o_result.byte_role = ROLE_NONE;
        endcase
        o_result.frame_done   = done;
        o_result.frame_ok     = done & n_ok;
        o_result.frame_ver    = done ? n_ver : '0;
        o_result.frame_format = n_fmt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_pos   <= '0;
            r_acc   <= '0;
            r_fep   <= '0;
            r_ver   <= '0;
            r_fmt   <= FMT_LEGACY;
            r_ok    <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_fep   <= n_fep;
            r_ver   <= n_ver;
            r_fmt   <= n_fmt;
            r_ok    <= n_ok;
        end
    end

endmodule

`default_nettype wire

[verif/doc_bundle_frame_parser_tb.sv]
//------------------------------------------------------------------------------
// doc_bundle_frame_parser_tb
// Self-checking bench for the frame parser. A short table of hand-written
// words comes first, then random frames of every format. The frames are
// mostly well formed, with some broken lengths, truncation and noise.
// The frames run under several magic settings. Each word that goes in is
// run through a local copy of the parser. The word that comes out is
// compared field by field against the oldest prediction.
//------------------------------------------------------------------------------

module doc_bundle_frame_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dbfp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 64;
    localparam int REPORT_LIMIT = 10;
    localparam int LEN_MAX_IN   = (1 << IN_LEN_W) - 1;

    localparam longint unsigned WORD_L  = 64'(WORD_BYTES);
    localparam longint unsigned PAIR_L  = 64'(LEN_PAIR_BYTES);
    localparam longint unsigned FRAME_L = 64'(MAX_FRAME_BYTES_DEF);

    typedef struct {
        logic [BYTE_W-1:0]   data;
        logic [IN_LEN_W-1:0] len;
    } t_word;

    typedef struct {
        t_word   w;
        bit      pinned;
        t_result want;
    } t_table_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_frame_byte;
    logic [IN_LEN_W-1:0]  i_frame_length;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [BYTE_W-1:0]    o_out_byte;
    logic [ROLE_W-1:0]    o_byte_role;
    logic                 o_frame_done;
    logic                 o_frame_ok;
    logic [ACC_W-1:0]     o_frame_ver;
    logic [FMT_W-1:0]     o_frame_format;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;

    // local copy of the parser state
    t_cfg             magic_cfg  = '{legacy_magic: LEGACY_MAGIC_RST, v1_magic: V1_MAGIC_RST,
                                     v2_magic: V2_MAGIC_RST};
    t_phase           parse_at   = PH_MAGIC;
    int unsigned      byte_pos   = 0;
    logic [ACC_W-1:0] shift_acc  = '0;
    longint unsigned  field_end  = 0;
    logic [ACC_W-1:0] slot_ver   = '0;
    logic [FMT_W-1:0] fmt_now    = FMT_LEGACY;
    bit               verdict_ok = 1'b0;

    t_result     results_due[$];
    t_table_row  directed_rows[$];
    t_word       frame_words[$];

    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned mismatch_count;
    int unsigned frames_by_fmt[4];
    int unsigned frames_passed;
    int unsigned settings_used;
    int unsigned holds_done;
    int unsigned cycle_count;
    int unsigned gap_odds;
    bit          quiet_run;
    bit          hold_request;

    doc_bundle_frame_parser u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_frame_byte   (i_frame_byte),
        .i_frame_length (i_frame_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_role    (o_byte_role),
        .o_frame_done   (o_frame_done),
        .o_frame_ok     (o_frame_ok),
        .o_frame_ver    (o_frame_ver),
        .o_frame_format (o_frame_format),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    //--------------------------------------------------------------------------
    // parser prediction
    //--------------------------------------------------------------------------
    function automatic void fail_frame();
        parse_at   = PH_FAIL;
        verdict_ok = 1'b0;
    endfunction

    function automatic void open_body_length(longint unsigned flen);
        if (field_end + WORD_L > flen) begin
            fail_frame();
        end else begin
            parse_at  = PH_BLEN;
            field_end = field_end + WORD_L;
        end
    endfunction

    function automatic t_result classify_byte(logic [BYTE_W-1:0] b,
                                              logic [IN_LEN_W-1:0] len_in);
        longint unsigned flen;
        longint unsigned nxt;
        t_result         r;
        bit              done;
        flen = (len_in == '0) ? 64'd1 : 64'(len_in);
        if (flen > FRAME_L) flen = FRAME_L;
        nxt = 64'(byte_pos) + 64'd1;
        r = '0;
        r.out_byte  = b;
        r.byte_role = ROLE_NONE;
        case (parse_at)
            PH_MAGIC: begin
                slot_ver   = '0;
                shift_acc  = '0;
                verdict_ok = 1'b0;
                // legacy beats version two, version two beats version one
                if (b == magic_cfg.legacy_magic) begin
                    fmt_now    = FMT_LEGACY;
                    parse_at   = PH_LIDX;
                    verdict_ok = 1'b1;
                end else if (b == magic_cfg.v2_magic) begin
                    fmt_now = FMT_V2;
                    if (flen < nxt + WORD_L + PAIR_L) begin
                        fail_frame();
                    end else begin
                        parse_at  = PH_VER;
                        field_end = nxt + WORD_L;
                    end
                end else if (b == magic_cfg.v1_magic) begin
                    fmt_now = FMT_V1;
                    if (flen < nxt + PAIR_L) begin
                        fail_frame();
                    end else begin
                        parse_at  = PH_ILEN;
                        field_end = nxt + WORD_L;
                    end
                end else begin
                    fmt_now     = FMT_UNKNOWN;
                    parse_at    = PH_UNK;
                    r.byte_role = ROLE_BODY;
                end
            end
            PH_VER: begin
                shift_acc = {b, shift_acc[ACC_W-1:BYTE_W]};
                if (nxt >= field_end) begin
                    slot_ver  = shift_acc;
                    parse_at  = PH_ILEN;
                    field_end = nxt + WORD_L;
                end
            end
            PH_ILEN: begin
                shift_acc = {b, shift_acc[ACC_W-1:BYTE_W]};
                if (nxt >= field_end) begin
                    field_end = nxt + 64'(shift_acc);
                    if (field_end > flen) begin
                        fail_frame();
                    end else if (shift_acc == '0) begin
                        open_body_length(flen);
                    end else begin
                        parse_at = PH_IDX;
                    end
                end
            end
            PH_IDX: begin
                r.byte_role = ROLE_INDEX;
                if (nxt >= field_end) open_body_length(flen);
            end
            PH_BLEN: begin
                shift_acc = {b, shift_acc[ACC_W-1:BYTE_W]};
                if (nxt >= field_end) begin
                    field_end = nxt + 64'(shift_acc);
                    if (field_end > flen) begin
                        fail_frame();
                    end else if (shift_acc == '0) begin
                        parse_at   = PH_PAD;
                        verdict_ok = 1'b1;
                    end else begin
                        parse_at = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                r.byte_role = ROLE_BODY;
                if (nxt >= field_end) begin
                    parse_at   = PH_PAD;
                    verdict_ok = 1'b1;
                end
            end
            PH_LIDX: begin
                if (b != '0) r.byte_role = ROLE_INDEX;
                else parse_at = PH_LREST;
            end
            PH_UNK: begin
                r.byte_role = ROLE_BODY;
            end
            PH_FAIL: begin
                verdict_ok = 1'b0;
            end
            default: begin
            end
        endcase
        done = (nxt >= flen);
        r.frame_done   = done;
        r.frame_ok     = done & verdict_ok;
        r.frame_ver    = done ? slot_ver : '0;
        r.frame_format = fmt_now;
        if (done) begin
            parse_at = PH_MAGIC;
            byte_pos = 0;
        end else begin
            byte_pos = 32'(nxt);
        end
        return r;
    endfunction

    //--------------------------------------------------------------------------
    // stimulus helpers
    //--------------------------------------------------------------------------
    function automatic void plain_row(logic [BYTE_W-1:0] b, logic [IN_LEN_W-1:0] len);
        t_table_row row;
        row.w.data = b;
        row.w.len  = len;
        row.pinned = 1'b0;
        row.want   = '0;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void pinned_row(logic [BYTE_W-1:0] b, logic [IN_LEN_W-1:0] len,
                                       logic [ROLE_W-1:0] role, bit done, bit ok,
                                       logic [ACC_W-1:0] ver, logic [FMT_W-1:0] fmt);
        t_table_row row;
        row.w.data              = b;
        row.w.len               = len;
        row.pinned              = 1'b1;
        row.want.out_byte       = b;
        row.want.byte_role      = role;
        row.want.frame_done     = done;
        row.want.frame_ok       = ok;
        row.want.frame_ver      = ver;
        row.want.frame_format   = fmt;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_byte(logic [BYTE_W-1:0] b);
        t_word wd;
        wd.data = b;
        wd.len  = '0;
        frame_words.insert(frame_words.size(), wd);
    endfunction

    function automatic void add_le32(logic [ACC_W-1:0] v);
        for (int k = 0; k < WORD_BYTES; k++) add_byte(v[BYTE_W*k +: BYTE_W]);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(t_word w, bit pinned, t_result want);
        t_result r;
        i_in_valid     <= 1'b1;
        i_frame_byte   <= w.data;
        i_frame_length <= w.len;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = classify_byte(w.data, w.len);
        words_sent++;
        if (r.frame_done) begin
            frames_by_fmt[r.frame_format]++;
            if (r.frame_ok) frames_passed++;
        end
        results_due.insert(results_due.size(), pinned ? want : r);
        @(negedge i_clk);
        if (!quiet_run && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
    endtask

    // sender goes quiet until every predicted word has come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_magics(t_cfg c);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LEGACY_MAGIC;
        i_cfg_data  <= c.legacy_magic;
        @(negedge i_clk);
        i_cfg_index <= CFG_V1_MAGIC;
        i_cfg_data  <= c.v1_magic;
        @(negedge i_clk);
        i_cfg_index <= CFG_V2_MAGIC;
        i_cfg_data  <= c.v2_magic;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        magic_cfg = c;
        settings_used++;
    endtask

    task automatic run_phase(t_cfg c, int unsigned n_words, bit with_hold);
        int unsigned         start_words;
        int unsigned         kind;
        int unsigned         flaw;
        int unsigned         n_idx;
        int unsigned         n_body;
        int unsigned         n_pad;
        int unsigned         cut;
        int unsigned         flen;
        bit                  noise;
        bit                  hold_sent;
        logic [ACC_W-1:0]    idx_field;
        logic [ACC_W-1:0]    body_field;
        logic [BYTE_W-1:0]   lead;
        t_word               tail;
        settle();
        set_magics(c);
        start_words = words_sent;
        hold_sent   = 1'b0;
        while (words_sent - start_words < n_words) begin
            // close any frame left open so the next one starts at its magic
            if (byte_pos != 0) begin
                tail.data = BYTE_W'($urandom_range(0, 255));
                tail.len  = IN_LEN_W'(byte_pos + 1);
                send_word(tail, 1'b0, '0);
            end
            frame_words.delete();
            noise    = 1'b0;
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
            kind     = $urandom_range(0, 99);
            flaw     = $urandom_range(0, 9);
            if (with_hold && !hold_sent && words_sent - start_words >= 40) begin
                hold_request = 1'b1;
                hold_sent    = 1'b1;
                gap_odds     = 0;
            end
            if (kind < 60) begin
                n_idx      = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
                n_body     = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
                n_pad      = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                idx_field  = n_idx;
                body_field = n_body;
                if (flaw == 0) begin
                    idx_field = $urandom_range(0, 1) ? $urandom()
                                : n_idx + n_body + n_pad + $urandom_range(1, 8);
                end else if (flaw == 1) begin
                    body_field = $urandom_range(0, 1) ? $urandom()
                                 : n_body + n_pad + $urandom_range(1, 4);
                end
                add_byte(kind < 30 ? c.v1_magic : c.v2_magic);
                if (kind >= 30) add_le32($urandom());
                add_le32(idx_field);
                repeat (n_idx) add_byte(BYTE_W'($urandom_range(0, 255)));
                add_le32(body_field);
                repeat (n_body) add_byte(BYTE_W'($urandom_range(0, 255)));
                repeat (n_pad) add_byte(BYTE_W'($urandom_range(0, 255)));
            end else if (kind < 75) begin
                add_byte(c.legacy_magic);
                repeat ($urandom_range(0, 10)) add_byte(BYTE_W'($urandom_range(1, 255)));
                if ($urandom_range(0, 3) != 0) add_byte(8'h00);
                repeat ($urandom_range(0, 5)) add_byte(BYTE_W'($urandom_range(0, 255)));
            end else if (kind < 87) begin
                lead = BYTE_W'($urandom_range(0, 255));
                while (lead == c.legacy_magic || lead == c.v1_magic || lead == c.v2_magic)
                    lead = lead + 8'd1;
                add_byte(lead);
                repeat ($urandom_range(0, 15)) add_byte(BYTE_W'($urandom_range(0, 255)));
            end else begin
                // stray words, each with a length of its own
                noise = 1'b1;
                repeat ($urandom_range(1, 6)) begin
                    add_byte(BYTE_W'($urandom_range(0, 255)));
                    frame_words[frame_words.size()-1].len =
                        IN_LEN_W'($urandom_range(0, LEN_MAX_IN));
                end
            end
            if (!noise) begin
                flen = frame_words.size();
                if (flaw == 2) begin
                    cut = $urandom_range(1, frame_words.size());
                    while (frame_words.size() > cut) void'(frame_words.pop_back());
                    flen = cut;
                end
                foreach (frame_words[i]) frame_words[i].len = IN_LEN_W'(flen);
                // length that moves within a frame
                if ($urandom_range(0, 19) == 0)
                    frame_words[$urandom_range(0, frame_words.size()-1)].len =
                        IN_LEN_W'($urandom_range(0, LEN_MAX_IN));
            end
            foreach (frame_words[i]) send_word(frame_words[i], 1'b0, '0);
        end
    endtask

    //--------------------------------------------------------------------------
    // output side: ready in random runs, one long hold on request
    //--------------------------------------------------------------------------
    initial begin : out_side
        int unsigned span;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                span = LONG_HOLD;
                holds_done++;
            end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                span = $urandom_range(1, 18);
            end else begin
                i_out_ready <= 1'b1;
                span = $urandom_range(1, 30);
            end
            repeat (span - 1) @(negedge i_clk);
        end
    end

    //--------------------------------------------------------------------------
    // result checking
    //--------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.out_byte     = o_out_byte;
            got.byte_role    = o_byte_role;
            got.frame_done   = o_frame_done;
            got.frame_ok     = o_frame_ok;
            got.frame_ver    = o_frame_ver;
            got.frame_format = o_frame_format;
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: word with nothing pending: byte %h role %0d fmt %0d",
                             $realtime, got.out_byte, got.byte_role, got.frame_format);
            end else begin
                want = results_due.pop_front();
                words_checked++;
                if (got.out_byte !== want.out_byte || got.byte_role !== want.byte_role ||
                    got.frame_done !== want.frame_done || got.frame_ok !== want.frame_ok ||
                    got.frame_ver !== want.frame_ver ||
                    got.frame_format !== want.frame_format) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch on word %0d", $realtime, words_checked);
                        $display("  want byte %h role %0d done %0d ok %0d ver %h fmt %0d",
                                 want.out_byte, want.byte_role, want.frame_done,
                                 want.frame_ok, want.frame_ver, want.frame_format);
                        $display("  got  byte %h role %0d done %0d ok %0d ver %h fmt %0d",
                                 got.out_byte, got.byte_role, got.frame_done,
                                 got.frame_ok, got.frame_ver, got.frame_format);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d words pending", cycle_count,
                 results_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    //--------------------------------------------------------------------------
    // main sequence
    //--------------------------------------------------------------------------
    initial begin : stimulus
        t_cfg setting;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_frame_byte   = '0;
        i_frame_length = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_LEGACY_MAGIC;
        i_cfg_data     = '0;
        quiet_run      = 1'b0;
        hold_request   = 1'b0;
        gap_odds       = 4;

        // magics at their reset values here
        pinned_row(8'hFF, 13'd1,  ROLE_BODY,  1'b1, 1'b0, '0, FMT_UNKNOWN);
        pinned_row(8'h00, 13'd0,  ROLE_NONE,  1'b1, 1'b1, '0, FMT_LEGACY); // zero length acts as one
        pinned_row(8'h01, 13'd1,  ROLE_NONE,  1'b1, 1'b0, '0, FMT_V1);     // too short for a header
        pinned_row(8'h02, 13'd12, ROLE_NONE,  1'b0, 1'b0, '0, FMT_V2);     // one short of a v2 header
        pinned_row(8'h00, 13'd2,  ROLE_NONE,  1'b1, 1'b0, '0, FMT_V2);     // length shrinks, frame ends
        pinned_row(8'h55, IN_LEN_W'(LEN_MAX_IN), ROLE_BODY, 1'b0, 1'b0, '0,
                   FMT_UNKNOWN);                                           // clamped, not done
        pinned_row(8'hAA, 13'd2,  ROLE_BODY,  1'b1, 1'b0, '0, FMT_UNKNOWN);
        pinned_row(8'h00, 13'd3,  ROLE_NONE,  1'b0, 1'b0, '0, FMT_LEGACY);
        pinned_row(8'hFF, 13'd3,  ROLE_INDEX, 1'b0, 1'b0, '0, FMT_LEGACY);
        pinned_row(8'h00, 13'd3,  ROLE_NONE,  1'b1, 1'b1, '0, FMT_LEGACY);
        // smallest v2 frame: slot version, empty index, empty body
        plain_row(8'h02, 13'd13);
        plain_row(8'hEF, 13'd13);
        plain_row(8'hBE, 13'd13);
        plain_row(8'hAD, 13'd13);
        plain_row(8'hDE, 13'd13);
        repeat (7) plain_row(8'h00, 13'd13);
        pinned_row(8'h00, 13'd13, ROLE_NONE,  1'b1, 1'b1, 32'hDEAD_BEEF, FMT_V2);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].pinned, directed_rows[i].want);

        setting = '{legacy_magic: LEGACY_MAGIC_RST, v1_magic: V1_MAGIC_RST,
                    v2_magic: V2_MAGIC_RST};
        run_phase(setting, 300, 1'b0);
        setting = '{legacy_magic: 8'hFF, v1_magic: 8'h00, v2_magic: 8'h80};
        run_phase(setting, 300, 1'b1);
        // all three equal: legacy takes it
        setting = '{legacy_magic: 8'h07, v1_magic: 8'h07, v2_magic: 8'h07};
        run_phase(setting, 200, 1'b0);
        // v1 and v2 equal: v2 takes it
        setting = '{legacy_magic: 8'hC8, v1_magic: 8'h09, v2_magic: 8'h09};
        run_phase(setting, 250, 1'b0);
        setting.legacy_magic = BYTE_W'($urandom_range(0, 255));
        setting.v1_magic     = BYTE_W'($urandom_range(0, 255));
        setting.v2_magic     = BYTE_W'($urandom_range(0, 255));
        run_phase(setting, 250, 1'b0);
        quiet_run = 1'b1;
        setting = '{legacy_magic: 8'h00, v1_magic: 8'hFF, v2_magic: 8'h01};
        run_phase(setting, 300, 1'b0);

        settle();
        repeat (8) @(negedge i_clk);

        $display("ran %0d words through %0d magic settings with %0d long output hold(s)",
                 words_sent, settings_used, holds_done);
        $display("frames closed: legacy %0d, v1 %0d, v2 %0d, unknown %0d, %0d passed",
                 frames_by_fmt[FMT_LEGACY], frames_by_fmt[FMT_V1], frames_by_fmt[FMT_V2],
                 frames_by_fmt[FMT_UNKNOWN], frames_passed);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d words still pending", mismatch_count,
                     results_due.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
